// File: rtl/gna_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the grid average block.
package gna_pkg;

  // Grid geometry
  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLS    = 64;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int CELL_AW     = ROW_W + COL_W;
  localparam int ADDR_W      = CELL_AW + 1;
  localparam int STORE_DEPTH = 2 * MAX_ROWS * MAX_COLS;

  // Scan counters reach one position past the grid on each axis
  localparam int SR_W = ROW_W + 1;
  localparam int SC_W = COL_W + 1;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int VAL_W     = 16;
  localparam int LEVEL_W   = 2;
  localparam int NR_W      = 6;
  localparam int NC_W      = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 7;

  // Region registers after reset
  localparam int ROWS_RESET = 25;
  localparam int COLS_RESET = 61;

  // Q1.15 one
  localparam int ONE_Q15 = 32768;

  // Arithmetic widths: column sum of three, window sum of nine, reciprocal product
  localparam int VS_W   = VAL_W + 1;
  localparam int HS_W   = VAL_W + 3;
  localparam int MUL_W  = 20;
  localparam int PROD_W = HS_W + MUL_W;
  localparam int TRI_W  = VAL_W + 2;

  // Exact floor division by 3 and 9 for dividends below 2^19
  localparam logic [MUL_W-1:0] RECIP3 = MUL_W'(699051);
  localparam int               SHIFT3 = 21;
  localparam logic [MUL_W-1:0] RECIP9 = MUL_W'(932068);
  localparam int               SHIFT9 = 23;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_t;

  // Source of the pending result
  typedef enum logic [1:0] {
    CAP_ZERO,
    CAP_WRITE,
    CAP_READ,
    CAP_STEP
  } cap_t;

  typedef struct packed {
    logic clear_en;
    logic wr_cell;
    logic scan_start;
    logic scan_en;
    logic bank_flip;
    logic cap_en;
    cap_t cap_sel;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic pipe_busy;
  } dp_stat_t;

endpackage

// File: rtl/gna_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
module gna_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/gna_ctrl.sv
`timescale 1ns / 1ps
// Controller: command sequencing, clearing pass, step sweep and result hand-off.
module gna_ctrl import gna_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] cmd,
  output logic             out_valid,
  input  logic             out_stall,
  output dp_cmd_t          ctl,
  input  dp_stat_t         stat
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DRAIN,
    ST_DELIVER
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Decode state into datapath commands
  always_comb begin
    state_next  = state;
    ctl         = '0;
    ctl.cap_sel = CAP_ZERO;
    case (state)
      ST_CLEAR: begin
        ctl.clear_en = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(cmd))
            CMD_WRITE: begin
              ctl.wr_cell = 1'b1;
              ctl.cap_en  = 1'b1;
              ctl.cap_sel = CAP_WRITE;
              state_next  = ST_DELIVER;
            end
            CMD_READ: begin
              state_next = ST_READ;
            end
            CMD_STEP: begin
              ctl.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
            default: begin
              ctl.cap_en  = 1'b1;
              ctl.cap_sel = CAP_ZERO;
              state_next  = ST_DELIVER;
            end
          endcase
        end
      end
      ST_READ: begin
        ctl.cap_en  = 1'b1;
        ctl.cap_sel = CAP_READ;
        state_next  = ST_DELIVER;
      end
      ST_SCAN: begin
        ctl.scan_en = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          ctl.bank_flip = 1'b1;
          ctl.cap_en    = 1'b1;
          ctl.cap_sel   = CAP_STEP;
          state_next    = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/gna_datapath.sv
`timescale 1ns / 1ps
// Datapath: cell store, line buffers, 3x3 averaging pipeline, config and result registers.
module gna_datapath import gna_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              ctl,
  output dp_stat_t             stat,
  input  logic [ROW_W-1:0]     row,
  input  logic [COL_W-1:0]     col,
  input  logic [VAL_W-1:0]     cell_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output logic [VAL_W-1:0]     read_value,
  output logic [LEVEL_W-1:0]   level,
  output logic                 step_done
);

  function automatic logic [LEVEL_W-1:0] level_of(input logic [VAL_W-1:0] v);
    level_of = v[VAL_W-1] ? '1 : v[VAL_W-2:VAL_W-3];
  endfunction

  // Region, bank and sweep control
  logic [SR_W-1:0]    nr;
  logic [SC_W-1:0]    nc;
  logic               bank;
  logic [CELL_AW-1:0] clear_addr;
  logic [SR_W-1:0]    sr;
  logic [SC_W-1:0]    sc;

  // Cell store ports
  logic              cell_we;
  logic [ADDR_W-1:0] cell_waddr;
  logic [VAL_W-1:0]  cell_wdata;
  logic [ADDR_W-1:0] cell_raddr;
  logic [VAL_W-1:0]  cell_rdata;
  logic [VAL_W-1:0]  sat_value;

  // Line buffer: upper half two rows back, lower half one row back
  logic               lb_we;
  logic [2*VAL_W-1:0] lb_wdata;
  logic [2*VAL_W-1:0] lb_rdata;
  logic [VAL_W-1:0]   lb_up1;
  logic [VAL_W-1:0]   lb_up2;

  // Stage 1
  logic            v1;
  logic [SR_W-1:0] r1;
  logic [SC_W-1:0] c1;
  logic            in0, in1, in2, col_ok;
  logic [VS_W-1:0] vs;

  // Stage 2
  logic             v2;
  logic [SR_W-1:0]  r2;
  logic [SC_W-1:0]  c2;
  logic [VS_W-1:0]  vs2, vs_a, vs_b;
  logic [VAL_W-1:0] raw2, raw_a;
  logic [SR_W-1:0]  rr;
  logic [SC_W-1:0]  cc;
  logic             wr_ok, inreg;
  logic             top, bot, lft, rgt;
  logic [HS_W-1:0]  hs;
  logic [1:0]       p_cnt, n_cnt;

  // Stage 3
  logic               v3;
  logic [CELL_AW-1:0] addr3;
  logic               inreg3;
  logic [VAL_W-1:0]   raw3;
  logic [HS_W-1:0]    hs3;
  logic [1:0]         p3, n3;
  logic [HS_W-1:0]    x3;
  logic [MUL_W-1:0]   recip;

  // Stage 4
  logic               v4;
  logic [CELL_AW-1:0] addr4;
  logic               inreg4;
  logic [VAL_W-1:0]   raw4;
  logic [PROD_W-1:0]  prod4;
  logic [1:0]         n4;
  logic [PROD_W-1:0]  quot;
  logic [VAL_W-1:0]   avg;
  logic [TRI_W-1:0]   triple;
  logic [VAL_W-1:0]   mapped;
  logic [VAL_W-1:0]   wdata4;

  // Pending result
  logic [VAL_W-1:0] pend_value;
  logic             pend_done;

  // Hold region registers, saturated on write
  always_ff @(posedge clk) begin
    if (rst) begin
      nr <= SR_W'(ROWS_RESET);
      nc <= SC_W'(COLS_RESET);
    end else if (cfg_we) begin
      if (cfg_index == REG_ROWS) begin
        nr <= (cfg_data[NR_W-1:0] > NR_W'(MAX_ROWS)) ? SR_W'(MAX_ROWS)
                                                     : SR_W'(cfg_data[NR_W-1:0]);
      end else if (cfg_index == REG_COLS) begin
        nc <= (cfg_data[NC_W-1:0] > NC_W'(MAX_COLS)) ? SC_W'(MAX_COLS)
                                                     : SC_W'(cfg_data[NC_W-1:0]);
      end
    end
  end

  // Advance clearing address, sweep counters and active bank
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
      sr         <= '0;
      sc         <= '0;
      bank       <= 1'b0;
    end else begin
      if (ctl.clear_en) begin
        clear_addr <= clear_addr + CELL_AW'(1);
      end
      if (ctl.scan_start) begin
        sr <= '0;
        sc <= '0;
      end else if (ctl.scan_en) begin
        if (sc == SC_W'(MAX_COLS)) begin
          sc <= '0;
          sr <= sr + SR_W'(1);
        end else begin
          sc <= sc + SC_W'(1);
        end
      end
      if (ctl.bank_flip) begin
        bank <= ~bank;
      end
    end
  end

  assign stat.clear_last = (clear_addr == '1);
  assign stat.scan_last  = (sr == SR_W'(MAX_ROWS)) && (sc == SC_W'(MAX_COLS));
  assign stat.pipe_busy  = v1 | v2 | v3 | v4;

  // Cell store port selection
  assign sat_value  = (cell_value > VAL_W'(ONE_Q15)) ? VAL_W'(ONE_Q15) : cell_value;
  assign cell_raddr = ctl.scan_en ? {bank, sr[ROW_W-1:0], sc[COL_W-1:0]} : {bank, row, col};

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = {~bank, addr4};
    cell_wdata = wdata4;
    if (ctl.clear_en) begin
      cell_we    = 1'b1;
      cell_waddr = {1'b0, clear_addr};
      cell_wdata = '0;
    end else if (ctl.wr_cell) begin
      cell_we    = 1'b1;
      cell_waddr = {bank, row, col};
      cell_wdata = sat_value;
    end else if (v4) begin
      cell_we = 1'b1;
    end
  end

  gna_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STORE_DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  gna_ram #(
    .WIDTH (2 * VAL_W),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (lb_we),
    .waddr (c1[COL_W-1:0]),
    .wdata (lb_wdata),
    .raddr (sc[COL_W-1:0]),
    .rdata (lb_rdata)
  );

  // Stage 1: mask cells outside the region, sum the column of three, shift rows down
  assign lb_up1   = lb_rdata[VAL_W-1:0];
  assign lb_up2   = lb_rdata[2*VAL_W-1:VAL_W];
  assign col_ok   = (c1 < nc);
  assign in0      = (r1 < nr) && col_ok;
  assign in1      = (r1 != '0) && ((r1 - SR_W'(1)) < nr) && col_ok;
  assign in2      = (r1 >= SR_W'(2)) && ((r1 - SR_W'(2)) < nr) && col_ok;
  assign vs       = (in0 ? VS_W'(cell_rdata) : '0) + (in1 ? VS_W'(lb_up1) : '0)
                  + (in2 ? VS_W'(lb_up2) : '0);
  assign lb_we    = v1 && (c1 < SC_W'(MAX_COLS));
  assign lb_wdata = {lb_up1, cell_rdata};

  // Stage 2: window sum over three columns, neighbour count of the centre cell
  assign rr    = r2 - SR_W'(1);
  assign cc    = c2 - SC_W'(1);
  assign wr_ok = v2 && (r2 != '0) && (c2 != '0);
  assign inreg = (rr < nr) && (cc < nc);
  assign top   = (rr != '0);
  assign bot   = ((rr + SR_W'(1)) < nr);
  assign lft   = (cc != '0);
  assign rgt   = ((cc + SC_W'(1)) < nc);
  assign hs    = HS_W'(vs2) + HS_W'(vs_a) + HS_W'(vs_b);
  assign p_cnt = {1'b0, top ^ bot} + {1'b0, lft ^ rgt};
  assign n_cnt = {1'b0, top & bot} + {1'b0, lft & rgt};

  // Stage 3: drop factors of two, pick reciprocal for factors of three
  assign x3 = hs3 >> p3;
  always_comb begin
    case (n3)
      2'd1:    recip = RECIP3;
      2'd2:    recip = RECIP9;
      default: recip = MUL_W'(1);
    endcase
  end

  // Stage 4: finish the division, apply the brightness map
  always_comb begin
    case (n4)
      2'd1:    quot = prod4 >> SHIFT3;
      2'd2:    quot = prod4 >> SHIFT9;
      default: quot = prod4;
    endcase
  end

  assign avg    = quot[VAL_W-1:0];
  assign triple = {1'b0, avg, 1'b0} + TRI_W'(avg);
  assign mapped = (triple <= TRI_W'(2 * ONE_Q15)) ? triple[VAL_W:1] : (avg >> 1);
  assign wdata4 = inreg4 ? mapped : raw4;

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= ctl.scan_en;
      v2 <= v1;
      v3 <= wr_ok;
      v4 <= v3;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    r1 <= sr;
    c1 <= sc;

    r2   <= r1;
    c2   <= c1;
    vs2  <= vs;
    raw2 <= lb_up1;

    if (v2) begin
      vs_a  <= vs2;
      vs_b  <= vs_a;
      raw_a <= raw2;
    end

    addr3  <= {rr[ROW_W-1:0], cc[COL_W-1:0]};
    inreg3 <= inreg;
    raw3   <= raw_a;
    hs3    <= hs;
    p3     <= p_cnt;
    n3     <= n_cnt;

    addr4  <= addr3;
    inreg4 <= inreg3;
    raw4   <= raw3;
    prod4  <= x3 * recip;
    n4     <= n3;
  end

  // Capture pending result, then load the output register
  always_ff @(posedge clk) begin
    if (ctl.cap_en) begin
      case (ctl.cap_sel)
        CAP_WRITE: begin
          pend_value <= sat_value;
          pend_done  <= 1'b0;
        end
        CAP_READ: begin
          pend_value <= cell_rdata;
          pend_done  <= 1'b0;
        end
        CAP_STEP: begin
          pend_value <= '0;
          pend_done  <= 1'b1;
        end
        default: begin
          pend_value <= '0;
          pend_done  <= 1'b0;
        end
      endcase
    end
    if (ctl.load_out) begin
      read_value <= pend_value;
      level      <= pend_done ? '0 : level_of(pend_value);
      step_done  <= pend_done;
    end
  end

endmodule

// File: rtl/grid_neighbour_average_step.sv
`timescale 1ns / 1ps
// Top level of the grid neighbour-average block: controller plus datapath.
//
//  channel  direction  handshake            payload
//  in       to block   in_valid / in_stall  cmd, row, col, cell_value
//  out      from block out_valid / out_stall read_value, level, step_done
//  cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// A write or an unused command is captured into the pending result and then loaded into
// the output register; a read passes through a read state first. A step sweeps 33 x 65
// raster positions through the cell store read port, one a cycle, plus a 4-stage drain.
// After reset a clearing pass zeroes the active bank with in_stall high.
// The next item is taken while a result waits in the output register; a stalled output
// holds the block before the following result is loaded. cfg_ready is always high.
module grid_neighbour_average_step import gna_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [ROW_W-1:0]     row,
  input  logic [COL_W-1:0]     col,
  input  logic [VAL_W-1:0]     cell_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VAL_W-1:0]     read_value,
  output logic [LEVEL_W-1:0]   level,
  output logic                 step_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  gna_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .stat      (stat)
  );

  gna_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .row        (row),
    .col        (col),
    .cell_value (cell_value),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .read_value (read_value),
    .level      (level),
    .step_done  (step_done)
  );

endmodule

// File: test/tb_grid_neighbour_average_step.sv
`timescale 1ns / 1ps
// Self-checking testbench for the grid neighbour-average block: directed table, then random phases.
module tb_grid_neighbour_average_step;
  import gna_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_PCT       = 29;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int DIRECTED_ROWS  = 24;
  localparam int PHASES         = 12;

  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic [LEVEL_W-1:0] lvl;
    logic               done;
  } grid_result_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    logic [VAL_W-1:0] v;
    logic             typed;
    grid_result_t     res;
  } table_row_t;

  typedef struct packed {
    logic [CFG_DAT_W-1:0] rows_cfg;
    logic [CFG_DAT_W-1:0] cols_cfg;
    logic [8:0]           items;
    logic                 steady;
    logic                 pick_region;
  } phase_t;

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     cmd        = '0;
  logic [ROW_W-1:0]     row        = '0;
  logic [COL_W-1:0]     col        = '0;
  logic [VAL_W-1:0]     cell_value = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [VAL_W-1:0]     read_value;
  logic [LEVEL_W-1:0]   level;
  logic                 step_done;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_data   = '0;

  // Predictor state: the current grid and the region registers
  logic [VAL_W-1:0] grid      [MAX_ROWS][MAX_COLS];
  logic [VAL_W-1:0] next_grid [MAX_ROWS][MAX_COLS];
  logic [NR_W-1:0]  rows_pred = NR_W'(ROWS_RESET);
  logic [NC_W-1:0]  cols_pred = NC_W'(COLS_RESET);

  grid_result_t pending_results[$];
  int           errors       = 0;
  int           idle_pct     = IDLE_PCT;
  int           quiet_cycles = 0;

  // Directed items; a set typed flag means the result is given here, else it is predicted
  table_row_t directed [DIRECTED_ROWS] = '{
    '{CMD_READ,   5'd0,  6'd0,  16'h0000, 1'b1, '{16'd0,     2'd0, 1'b0}},
    '{CMD_READ,   5'd31, 6'd63, 16'h0000, 1'b1, '{16'd0,     2'd0, 1'b0}},
    '{CMD_WRITE,  5'd0,  6'd0,  16'h8000, 1'b1, '{16'd32768, 2'd3, 1'b0}},
    '{CMD_WRITE,  5'd31, 6'd63, 16'hFFFF, 1'b1, '{16'd32768, 2'd3, 1'b0}},
    '{CMD_WRITE,  5'd1,  6'd1,  16'd8191, 1'b1, '{16'd8191,  2'd0, 1'b0}},
    '{CMD_WRITE,  5'd1,  6'd2,  16'd8192, 1'b1, '{16'd8192,  2'd1, 1'b0}},
    '{CMD_WRITE,  5'd2,  6'd1,  16'd16383, 1'b1, '{16'd16383, 2'd1, 1'b0}},
    '{CMD_WRITE,  5'd2,  6'd2,  16'd16384, 1'b1, '{16'd16384, 2'd2, 1'b0}},
    '{CMD_WRITE,  5'd3,  6'd3,  16'd24575, 1'b1, '{16'd24575, 2'd2, 1'b0}},
    '{CMD_WRITE,  5'd3,  6'd4,  16'd24576, 1'b1, '{16'd24576, 2'd3, 1'b0}},
    '{CMD_WRITE,  5'd0,  6'd60, 16'h7FFF, 1'b1, '{16'd32767, 2'd3, 1'b0}},
    '{CMD_UNUSED, 5'd31, 6'd63, 16'hFFFF, 1'b1, '{16'd0,     2'd0, 1'b0}},
    '{CMD_READ,   5'd0,  6'd0,  16'h0000, 1'b1, '{16'd32768, 2'd3, 1'b0}},
    '{CMD_STEP,   5'd0,  6'd0,  16'h0000, 1'b1, '{16'd0,     2'd0, 1'b1}},
    '{CMD_READ,   5'd0,  6'd0,  16'h0000, 1'b0, '0},
    '{CMD_READ,   5'd1,  6'd1,  16'h0000, 1'b0, '0},
    '{CMD_READ,   5'd31, 6'd63, 16'h0000, 1'b1, '{16'd32768, 2'd3, 1'b0}},
    '{CMD_READ,   5'd24, 6'd60, 16'h0000, 1'b0, '0},
    '{CMD_WRITE,  5'd24, 6'd60, 16'h8000, 1'b1, '{16'd32768, 2'd3, 1'b0}},
    '{CMD_READ,   5'd24, 6'd61, 16'h0000, 1'b1, '{16'd0,     2'd0, 1'b0}},
    '{CMD_STEP,   5'd0,  6'd0,  16'h0000, 1'b1, '{16'd0,     2'd0, 1'b1}},
    '{CMD_READ,   5'd24, 6'd60, 16'h0000, 1'b0, '0},
    '{CMD_READ,   5'd23, 6'd59, 16'h0000, 1'b0, '0},
    '{CMD_UNUSED, 5'd0,  6'd0,  16'h0000, 1'b1, '{16'd0,     2'd0, 1'b0}}
  };

  // Region settings per phase: extremes, masked and saturated values, zero regions
  phase_t phases [PHASES] = '{
    '{7'd3,   7'd3,   9'd40, 1'b0, 1'b0},
    '{7'd1,   7'd1,   9'd20, 1'b0, 1'b0},
    '{7'd32,  7'd64,  9'd30, 1'b0, 1'b0},
    '{7'd127, 7'd127, 9'd20, 1'b0, 1'b0},
    '{7'd64,  7'd5,   9'd15, 1'b0, 1'b0},
    '{7'd7,   7'd0,   9'd15, 1'b0, 1'b0},
    '{7'd0,   7'd0,   9'd10, 1'b0, 1'b0},
    '{7'd2,   7'd65,  9'd20, 1'b0, 1'b0},
    '{7'd32,  7'd1,   9'd20, 1'b0, 1'b0},
    '{7'd5,   7'd9,   9'd40, 1'b1, 1'b0},
    '{7'd0,   7'd0,   9'd40, 1'b0, 1'b1},
    '{7'd25,  7'd61,  9'd20, 1'b0, 1'b0}
  };

  grid_neighbour_average_step uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .row(row), .col(col), .cell_value(cell_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .level(level), .step_done(step_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [LEVEL_W-1:0] brightness_of(logic [VAL_W-1:0] v);
    if (v < 16'd8192) return 2'd0;
    if (v < 16'd16384) return 2'd1;
    if (v < 16'd24576) return 2'd2;
    return 2'd3;
  endfunction

  function automatic int rows_active();
    return (int'(rows_pred) > MAX_ROWS) ? MAX_ROWS : int'(rows_pred);
  endfunction

  function automatic int cols_active();
    return (int'(cols_pred) > MAX_COLS) ? MAX_COLS : int'(cols_pred);
  endfunction

  // Replace every cell of the region by the mapped mean of its in-region neighbourhood
  function automatic void average_grid();
    int nr;
    int nc;
    int unsigned sum;
    int unsigned cnt;
    int unsigned avg;
    nr = rows_active();
    nc = cols_active();
    next_grid = grid;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        sum = 0;
        cnt = 0;
        for (int k = (r > 0 ? r - 1 : 0); k <= (r + 1 < nr ? r + 1 : nr - 1); k++) begin
          for (int l = (c > 0 ? c - 1 : 0); l <= (c + 1 < nc ? c + 1 : nc - 1); l++) begin
            sum += grid[k][l];
            cnt++;
          end
        end
        avg = sum / cnt;
        next_grid[r][c] = (3 * avg <= 65536) ? VAL_W'((3 * avg) >> 1) : VAL_W'(avg >> 1);
      end
    end
    grid = next_grid;
  endfunction

  // Apply one command to the predicted grid and return its result
  function automatic grid_result_t apply_command(logic [CMD_W-1:0] op, logic [ROW_W-1:0] r,
                                                 logic [COL_W-1:0] c, logic [VAL_W-1:0] v);
    grid_result_t res;
    res = '0;
    if (op == CMD_WRITE) begin
      grid[r][c] = (v > VAL_W'(ONE_Q15)) ? VAL_W'(ONE_Q15) : v;
    end
    if (op == CMD_WRITE || op == CMD_READ) begin
      res.value = grid[r][c];
      res.lvl   = brightness_of(grid[r][c]);
    end else if (op == CMD_STEP) begin
      average_grid();
      res.done = 1'b1;
    end
    return res;
  endfunction

  // Offer one item, hold it until taken, then record what it should produce
  task automatic send_item(logic [CMD_W-1:0] op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                           logic [VAL_W-1:0] v, logic typed, grid_result_t given);
    grid_result_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    row        <= r;
    col        <= c;
    cell_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_command(op, r, c, v);
    pending_results.push_back(typed ? given : predicted);
  endtask

  // Write both region registers back to back
  task automatic set_region(logic [CFG_DAT_W-1:0] rows_cfg, logic [CFG_DAT_W-1:0] cols_cfg);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_data  <= rows_cfg;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rows_pred = rows_cfg[NR_W-1:0];
    cfg_index <= REG_COLS;
    cfg_data  <= cols_cfg;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cols_pred = cols_cfg[NC_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  // Random commands, most of them aimed inside the region, half of those near its origin
  task automatic send_random(int count);
    int pick;
    int nr;
    int nc;
    logic [CMD_W-1:0] op;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    logic [VAL_W-1:0] v;
    for (int i = 0; i < count; i++) begin
      nr   = rows_active();
      nc   = cols_active();
      pick = $urandom_range(0, 99);
      if (pick < 40) op = CMD_WRITE;
      else if (pick < 84) op = CMD_READ;
      else if (pick < 93) op = CMD_STEP;
      else op = CMD_UNUSED;
      if (nr > 0 && nc > 0 && $urandom_range(0, 99) < 75) begin
        if ($urandom_range(0, 1) == 1) begin
          r = ROW_W'($urandom_range(0, (nr < 6 ? nr : 6) - 1));
          c = COL_W'($urandom_range(0, (nc < 6 ? nc : 6) - 1));
        end else begin
          r = ROW_W'($urandom_range(0, nr - 1));
          c = COL_W'($urandom_range(0, nc - 1));
        end
      end else begin
        r = ROW_W'($urandom_range(0, MAX_ROWS - 1));
        c = COL_W'($urandom_range(0, MAX_COLS - 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) v = '0;
      else if (pick < 16) v = VAL_W'(ONE_Q15);
      else if (pick < 22) v = VAL_W'($urandom_range(ONE_Q15 + 1, 65535));
      else v = VAL_W'($urandom_range(0, ONE_Q15));
      send_item(op, r, c, v, 1'b0, '0);
    end
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Check each taken result against the oldest expectation; stall the output at random
  always @(posedge clk) begin : check_results
    grid_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: value %0d level %0d done %0d",
                 $time, read_value, level, step_done);
      end else begin
        want = pending_results.pop_front();
        if (read_value !== want.value) begin
          errors++;
          $display("%0t: read_value expected %0d actual %0d", $time, want.value, read_value);
        end
        if (level !== want.lvl) begin
          errors++;
          $display("%0t: level expected %0d actual %0d", $time, want.lvl, level);
        end
        if (step_done !== want.done) begin
          errors++;
          $display("%0t: step_done expected %0d actual %0d", $time, want.done, step_done);
        end
      end
    end
    out_stall <= !rst && ($urandom_range(0, 99) < idle_pct);
  end

  // End the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[grid_neighbour_average_step] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    for (int r = 0; r < MAX_ROWS; r++) begin
      for (int c = 0; c < MAX_COLS; c++) begin
        grid[r][c] = '0;
      end
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table with the reset region
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(directed[i].op, directed[i].r, directed[i].c, directed[i].v,
                directed[i].typed, directed[i].res);
    end
    in_valid <= 1'b0;
    wait_results_drained();

    // Random phases, each under its own region setting
    for (int p = 0; p < PHASES; p++) begin
      @(posedge clk);
      if (phases[p].pick_region) begin
        set_region(CFG_DAT_W'($urandom_range(1, MAX_ROWS)),
                   CFG_DAT_W'($urandom_range(1, MAX_COLS)));
      end else begin
        set_region(phases[p].rows_cfg, phases[p].cols_cfg);
      end
      idle_pct = phases[p].steady ? 0 : IDLE_PCT;
      send_random(int'(phases[p].items));
      in_valid <= 1'b0;
      wait_results_drained();
    end

    idle_pct = IDLE_PCT;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[grid_neighbour_average_step] OK");
    end else begin
      $display("[grid_neighbour_average_step] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/gna_pkg.sv
rtl/gna_ram.sv
rtl/gna_ctrl.sv
rtl/gna_datapath.sv
rtl/grid_neighbour_average_step.sv
test/tb_grid_neighbour_average_step.sv
